FILE: design/rrfs_pkg.sv
// ----------------------------------------------------------------------------
// rrfs_pkg: shared constants for the range rate block
// Axis count and output width used by the pipeline modules.
// ----------------------------------------------------------------------------
package rrfs_pkg;
  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned OUT_W    = 32;
endpackage

FILE: design/rrfs_if.sv
// ----------------------------------------------------------------------------
// rrfs_in_if / rrfs_out_if: valid/ready channels of the range rate block
// Input word carries target and sensor states; output word the range rate.
// ----------------------------------------------------------------------------
interface rrfs_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] target_pos_x, target_pos_y, target_pos_z;
  logic signed [31:0] target_vel_x, target_vel_y, target_vel_z;
  logic signed [31:0] sensor_pos_x, sensor_pos_y, sensor_pos_z;
  logic signed [31:0] sensor_vel_x, sensor_vel_y, sensor_vel_z;
  modport source (output valid, target_pos_x, target_pos_y, target_pos_z,
    target_vel_x, target_vel_y, target_vel_z, sensor_pos_x, sensor_pos_y,
    sensor_pos_z, sensor_vel_x, sensor_vel_y, sensor_vel_z, input ready);
  modport sink (input valid, target_pos_x, target_pos_y, target_pos_z,
    target_vel_x, target_vel_y, target_vel_z, sensor_pos_x, sensor_pos_y,
    sensor_pos_z, sensor_vel_x, sensor_vel_y, sensor_vel_z, output ready);
endinterface

interface rrfs_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] range_rate;
  logic zero_range;
  logic saturated;
  modport source (output valid, range_rate, zero_range, saturated, input ready);
  modport sink (input valid, range_rate, zero_range, saturated, output ready);
endinterface

FILE: design/rrfs_lane.sv
// ----------------------------------------------------------------------------
// rrfs_lane: one axis of the relative state
// Two stages: difference, then the two products dv*dp and dp*dp.
// ----------------------------------------------------------------------------
module rrfs_lane
  import rrfs_pkg::*;
#(
  parameter int unsigned CW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [CW-1:0]        tp,
  input  logic [CW-1:0]        tv,
  input  logic [CW-1:0]        sp,
  input  logic [CW-1:0]        sv,
  output logic signed [2*CW+1:0] dot_term,
  output logic [2*CW+1:0]      sq_term
);
  logic signed [CW:0] dp;
  logic signed [CW:0] dv;

  always_ff @(posedge clk) begin
    if (en) begin
      dp       <= (CW+1)'($signed(tp)) - (CW+1)'($signed(sp));
      dv       <= (CW+1)'($signed(tv)) - (CW+1)'($signed(sv));
      dot_term <= (2*CW+2)'(dp) * (2*CW+2)'(dv);
      sq_term  <= (2*CW+2)'(dp) * (2*CW+2)'(dp);
    end
  end
endmodule

FILE: design/rrfs_merge.sv
// ----------------------------------------------------------------------------
// rrfs_merge: adds the lane products into the dot product and squared range
// One registered stage; also splits sign and magnitude of the dot product.
// ----------------------------------------------------------------------------
module rrfs_merge
  import rrfs_pkg::*;
#(
  parameter int unsigned CW = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [2*CW+1:0]       dot_term [NUM_AXES],
  input  logic [2*CW+1:0]              sq_term  [NUM_AXES],
  output logic [2*CW+3:0]              dot_mag,
  output logic                         dot_neg,
  output logic [2*CW+3:0]              sq_sum
);
  logic signed [2*CW+3:0] dsum;

  always_comb begin
    dsum = (2*CW+4)'(dot_term[0]) + (2*CW+4)'(dot_term[1]) + (2*CW+4)'(dot_term[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_neg <= dsum[2*CW+3];
      dot_mag <= dsum[2*CW+3] ? (2*CW+4)'(-dsum) : (2*CW+4)'(dsum);
      sq_sum  <= (2*CW+4)'(sq_term[0]) + (2*CW+4)'(sq_term[1]) + (2*CW+4)'(sq_term[2]);
    end
  end
endmodule

FILE: design/rrfs_sqrt.sv
// ----------------------------------------------------------------------------
// rrfs_sqrt: pipelined restoring integer square root, one root bit a stage
// Carries the dividend and flags alongside.
// ----------------------------------------------------------------------------
module rrfs_sqrt
  import rrfs_pkg::*;
#(
  parameter int unsigned SW = 68,
  parameter int unsigned RW = 34
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] s_in,
  input  logic [SW-1:0] n_in,
  input  logic          neg_in,
  output logic [RW-1:0] root,
  output logic [SW-1:0] n_out,
  output logic          neg_out,
  output logic          zero_out
);
  // stage k decides root bit RW-1-k; rem tracks s - r*r
  logic [SW:0]   rem  [RW+1];
  logic [RW-1:0] r    [RW+1];
  logic [SW-1:0] n    [RW+1];
  logic          ng   [RW+1];
  logic          z    [RW+1];

  always_comb begin
    rem[0] = {1'b0, s_in};
    r[0]   = '0;
    n[0]   = n_in;
    ng[0]  = neg_in;
    z[0]   = (s_in == '0);
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic [SW+1:0] trial;
    always_comb begin
      // (r+2^B)^2 - r^2 = 2^(B+1)*r + 2^(2B)
      trial = ((SW+2)'(r[k]) << (B + 1)) + ((SW+2)'(1) << (2 * B));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if ((SW+2)'(rem[k]) >= trial) begin
          rem[k+1] <= (SW+1)'((SW+2)'(rem[k]) - trial);
          r[k+1]   <= r[k] | (RW'(1) << B);
        end else begin
          rem[k+1] <= rem[k];
          r[k+1]   <= r[k];
        end
        n[k+1]  <= n[k];
        ng[k+1] <= ng[k];
        z[k+1]  <= z[k];
      end
    end
  end

  assign root     = r[RW];
  assign n_out    = n[RW];
  assign neg_out  = ng[RW];
  assign zero_out = z[RW];
endmodule

FILE: design/rrfs_div.sv
// ----------------------------------------------------------------------------
// rrfs_div: pipelined restoring divider, one quotient bit a stage
// Only OUT_W+1 quotient bits are kept; higher ones fold into an overflow bit.
// ----------------------------------------------------------------------------
module rrfs_div
  import rrfs_pkg::*;
#(
  parameter int unsigned NW = 68,
  parameter int unsigned DW = 34
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       n_in,
  input  logic [DW-1:0]       d_in,
  input  logic                neg_in,
  input  logic                zero_in,
  output logic [OUT_W-1:0]    range_rate,
  output logic                saturated,
  output logic                zero_range
);
  localparam int unsigned QW = OUT_W + 1;
  // divisor shifted by QW: dividend at or above it means quotient >= 2^QW
  logic [NW+QW:0] big;
  logic           ovf0;
  always_comb begin
    big  = (NW+QW+1)'(d_in) << QW;
    ovf0 = ((NW+QW+1)'(n_in) >= big) && !zero_in;
  end

  logic [NW-1:0] rem [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic [DW-1:0] d   [QW+1];
  logic          ng  [QW+1];
  logic          z   [QW+1];
  logic          ov  [QW+1];

  always_comb begin
    rem[0] = n_in;
    q[0]   = '0;
    d[0]   = d_in;
    ng[0]  = neg_in;
    z[0]   = zero_in;
    ov[0]  = ovf0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    logic [NW+QW:0] sh;
    always_comb sh = (NW+QW+1)'(d[k]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ov[k] && ((NW+QW+1)'(rem[k]) >= sh)) begin
          rem[k+1] <= NW'((NW+QW+1)'(rem[k]) - sh);
          q[k+1]   <= q[k] | (QW'(1) << B);
        end else begin
          rem[k+1] <= rem[k];
          q[k+1]   <= q[k];
        end
        d[k+1]  <= d[k];
        ng[k+1] <= ng[k];
        z[k+1]  <= z[k];
        ov[k+1] <= ov[k];
      end
    end
  end

  logic [QW-1:0] qf;
  logic          pos_sat;
  logic          neg_sat;
  always_comb begin
    qf      = q[QW];
    pos_sat = ov[QW] || (qf > QW'({1'b0, {(OUT_W-1){1'b1}}}));
    neg_sat = ov[QW] || (qf > QW'({1'b1, {(OUT_W-1){1'b0}}}));
    if (z[QW]) begin
      range_rate = '0;
      saturated  = 1'b0;
    end else if (!ng[QW]) begin
      range_rate = pos_sat ? {1'b0, {(OUT_W-1){1'b1}}} : qf[OUT_W-1:0];
      saturated  = pos_sat;
    end else begin
      range_rate = neg_sat ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-qf);
      saturated  = neg_sat;
    end
    zero_range = z[QW];
  end
endmodule

FILE: design/range_rate_from_states.sv
// ----------------------------------------------------------------------------
// range_rate_from_states: range rate from target and sensor states
// Three axis lanes, a merge stage, a square root pipeline and a divider.
// ----------------------------------------------------------------------------
// A new word is taken every cycle while the output is not stalled. Three
// parallel lanes (one per axis) form the relative state and its products,
// a merge stage sums them into the dot product and squared range, a square
// root pipeline (one root bit a stage) gives the range, and a divider
// pipeline (one quotient bit a stage) gives the rate, truncated toward zero
// and saturated to 32 bits, into the output register. The whole pipe
// stalls while the output word waits, and a skid-free output register
// lets the next word enter as the current one is taken. Zero range gives 0
// with zero_range set.
// ----------------------------------------------------------------------------
module range_rate_from_states
  import rrfs_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  rrfs_in_if.sink    in_word,
  rrfs_out_if.source out_word
);
  localparam int unsigned CW = COMPONENT_WIDTH;
  localparam int unsigned SW = 2 * CW + 4;
  localparam int unsigned RW = CW + 2;
  localparam int unsigned LAT = 2 + 1 + RW + OUT_W + 1;

  // pipe advances unless the output register holds an untaken word
  logic en;
  logic [LAT-1:0] vld;
  assign en           = !out_word.valid || out_word.ready;
  assign in_word.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_word.valid};
    end
  end

  logic signed [2*CW+1:0] dot_term [NUM_AXES];
  logic [2*CW+1:0]        sq_term  [NUM_AXES];
  logic [CW-1:0] tp [NUM_AXES], tv [NUM_AXES], sp [NUM_AXES], sv [NUM_AXES];
  assign tp[0] = in_word.target_pos_x[CW-1:0];
  assign tp[1] = in_word.target_pos_y[CW-1:0];
  assign tp[2] = in_word.target_pos_z[CW-1:0];
  assign tv[0] = in_word.target_vel_x[CW-1:0];
  assign tv[1] = in_word.target_vel_y[CW-1:0];
  assign tv[2] = in_word.target_vel_z[CW-1:0];
  assign sp[0] = in_word.sensor_pos_x[CW-1:0];
  assign sp[1] = in_word.sensor_pos_y[CW-1:0];
  assign sp[2] = in_word.sensor_pos_z[CW-1:0];
  assign sv[0] = in_word.sensor_vel_x[CW-1:0];
  assign sv[1] = in_word.sensor_vel_y[CW-1:0];
  assign sv[2] = in_word.sensor_vel_z[CW-1:0];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rrfs_lane #(.CW(CW)) u_lane (
      .clk(clk), .en(en), .tp(tp[a]), .tv(tv[a]), .sp(sp[a]), .sv(sv[a]),
      .dot_term(dot_term[a]), .sq_term(sq_term[a])
    );
  end

  logic [SW-1:0] dot_mag, sq_sum;
  logic          dot_neg;
  rrfs_merge #(.CW(CW)) u_merge (
    .clk(clk), .en(en), .dot_term(dot_term), .sq_term(sq_term),
    .dot_mag(dot_mag), .dot_neg(dot_neg), .sq_sum(sq_sum)
  );

  logic [RW-1:0] root;
  logic [SW-1:0] num;
  logic          neg_s, zero_s;
  rrfs_sqrt #(.SW(SW), .RW(RW)) u_sqrt (
    .clk(clk), .en(en), .s_in(sq_sum), .n_in(dot_mag), .neg_in(dot_neg),
    .root(root), .n_out(num), .neg_out(neg_s), .zero_out(zero_s)
  );

  logic [OUT_W-1:0] rr;
  logic             sat, zr;
  rrfs_div #(.NW(SW), .DW(RW)) u_div (
    .clk(clk), .en(en), .n_in(num), .d_in(root), .neg_in(neg_s),
    .zero_in(zero_s), .range_rate(rr), .saturated(sat), .zero_range(zr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_word.valid <= 1'b0;
    end else if (en) begin
      out_word.valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.range_rate <= rr;
      out_word.zero_range <= zr;
      out_word.saturated  <= sat;
    end
  end

`ifndef ASSERT_OFF
  a_zero_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_word.valid |-> !(out_word.zero_range && out_word.saturated))
    else $error("zero range with saturation");
  a_zero_val: assert property (@(posedge clk) disable iff (rst)
    (out_word.valid && out_word.zero_range) |-> (out_word.range_rate == '0))
    else $error("zero range gives nonzero rate");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe moved during stall");
`endif
endmodule
